### hw/rtl/nns_pkg.sv
// Shared types and constants for the nearest-neighbour RGB565 scaler.
// No dependencies; every other file of the block imports this package.
package nns_pkg;

  localparam int COLOR_W    = 8;
  localparam int PIXEL_W    = 16;
  localparam int SRC_SIZE_W = 9;
  localparam int DST_SIZE_W = 11;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 11;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FLIP_ROWS  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DST_WIDTH  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_DST_HEIGHT = 3'd4;

  // Operation codes of an input word
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Colour truncation masks
  localparam logic [COLOR_W-1:0] RED_MASK   = 8'hF8;
  localparam logic [COLOR_W-1:0] GREEN_MASK = 8'hFC;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  // Command passed from the front end to the store
  typedef struct packed {
    logic               fetch;
    logic               last;
    logic [PIXEL_W-1:0] pixel;
  } cmd_t;

  function automatic logic [PIXEL_W-1:0] pack_rgb565(input logic [COLOR_W-1:0] r,
                                                      input logic [COLOR_W-1:0] g,
                                                      input logic [COLOR_W-1:0] b);
    logic [PIXEL_W-1:0] rr;
    logic [PIXEL_W-1:0] gg;
    logic [PIXEL_W-1:0] bb;
    rr = PIXEL_W'(r & RED_MASK) << 8;
    gg = PIXEL_W'(g & GREEN_MASK) << 3;
    bb = PIXEL_W'(b >> 3);
    return rr | gg | bb;
  endfunction

endpackage

### hw/rtl/nns_in_if.sv
// Input word channel of the scaler: valid/ready plus operation and colour bytes.
// Depends on nns_pkg.
interface nns_in_if import nns_pkg::*;;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [COLOR_W-1:0] blue;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] red;

  modport source (output valid, operation, blue, green, red, input ready);
  modport sink   (input valid, operation, blue, green, red, output ready);
endinterface

### hw/rtl/nns_out_if.sv
// Output word channel of the scaler: valid/ready plus pixel and frame mark.
// Depends on nns_pkg.
interface nns_out_if import nns_pkg::*;;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_rgb565;
  logic               last_of_frame;

  modport source (output valid, pixel_rgb565, last_of_frame, input ready);
  modport sink   (input valid, pixel_rgb565, last_of_frame, output ready);
endinterface

### hw/rtl/nns_fifo.sv
// Small command queue between the scaler front end and the store.
// Depends on nns_pkg.
module nns_fifo import nns_pkg::*; #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNW-1:0]   count;

  assign full     = (count == CNW'(DEPTH));
  assign valid    = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full && !pop |-> !push)
    else $error("queue written while full");

endmodule

### hw/rtl/nns_front.sv
// Front end: configuration registers, load and fetch counters, source
// coordinate division and command issue. Depends on nns_pkg and nns_in_if.
module nns_front import nns_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int MAX_DST_WIDTH  = 1024,
  parameter int MAX_DST_HEIGHT = 1024,
  localparam int AW = (MAX_SRC_WIDTH * MAX_SRC_HEIGHT > 1) ?
                      $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  nns_in_if.sink                 in,
  output logic                   push,
  output cmd_t                   push_cmd,
  output logic [AW-1:0]          push_addr,
  input  logic                   q_full
);

  localparam int LCW = (MAX_SRC_WIDTH > 1)  ? $clog2(MAX_SRC_WIDTH)  : 1;
  localparam int LRW = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
  localparam int CW  = (MAX_DST_WIDTH > 1)  ? $clog2(MAX_DST_WIDTH)  : 1;
  localparam int RW  = (MAX_DST_HEIGHT > 1) ? $clog2(MAX_DST_HEIGHT) : 1;
  localparam int SWW = $clog2(MAX_SRC_WIDTH + 1);
  localparam int SHW = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int DWW = $clog2(MAX_DST_WIDTH + 1);
  localparam int DHW = $clog2(MAX_DST_HEIGHT + 1);
  localparam int QB  = (LCW > LRW) ? LCW : LRW;
  localparam int NA  = (CW + SWW > RW + SHW) ? CW + SWW : RW + SHW;
  localparam int NB  = (DWW > DHW) ? DWW + QB : DHW + QB;
  localparam int NW  = (NA > NB) ? NA : NB;
  localparam int STW = (QB > 1) ? $clog2(QB) : 1;

  // configuration registers
  logic [SRC_SIZE_W-1:0] src_width;
  logic [SRC_SIZE_W-1:0] src_height;
  logic                  flip_rows;
  logic [DST_SIZE_W-1:0] dst_width;
  logic [DST_SIZE_W-1:0] dst_height;

  // clamped sizes
  logic [31:0]    sw_full, sh_full, dw_full, dh_full;
  logic [SWW-1:0] sw;
  logic [SHW-1:0] sh;
  logic [DWW-1:0] dw;
  logic [DHW-1:0] dh;

  // counters
  logic [LCW-1:0] load_column, load_column_next, lcol_eff;
  logic [LRW-1:0] load_row, load_row_next, lrow_eff;
  logic [CW-1:0]  out_column, out_column_next, ocol_eff;
  logic [RW-1:0]  out_row, out_row_next, orow_eff;
  logic [SWW-1:0] lcol_inc;
  logic [SHW-1:0] lrow_inc;
  logic [DWW-1:0] ocol_inc;
  logic [DHW-1:0] orow_inc;
  logic [SHW-1:0] wrow;
  logic [AW-1:0]  waddr;
  logic [AW-1:0]  raddr;
  logic           last_now;

  // division datapath
  front_state_t   state, state_next;
  logic [STW-1:0] step;
  logic [NW-1:0]  rem_x, rem_y, dsx, dsy;
  logic [QB-1:0]  qx, qy;
  logic           bit_x, bit_y;
  logic           last_hold;
  logic           accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= SRC_SIZE_W'(1);
      src_height <= SRC_SIZE_W'(1);
      flip_rows  <= 1'b1;
      dst_width  <= DST_SIZE_W'(1);
      dst_height <= DST_SIZE_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SRC_WIDTH:  src_width  <= cfg_data[SRC_SIZE_W-1:0];
        CFG_SRC_HEIGHT: src_height <= cfg_data[SRC_SIZE_W-1:0];
        CFG_FLIP_ROWS:  flip_rows  <= cfg_data[0];
        CFG_DST_WIDTH:  dst_width  <= cfg_data[DST_SIZE_W-1:0];
        CFG_DST_HEIGHT: dst_height <= cfg_data[DST_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // zero counts as one, oversize counts as the maximum
  assign sw_full = (src_width == '0) ? 32'd1 :
                   ((32'(src_width) > 32'(MAX_SRC_WIDTH)) ? 32'(MAX_SRC_WIDTH) : 32'(src_width));
  assign sh_full = (src_height == '0) ? 32'd1 :
                   ((32'(src_height) > 32'(MAX_SRC_HEIGHT)) ? 32'(MAX_SRC_HEIGHT) :
                    32'(src_height));
  assign dw_full = (dst_width == '0) ? 32'd1 :
                   ((32'(dst_width) > 32'(MAX_DST_WIDTH)) ? 32'(MAX_DST_WIDTH) : 32'(dst_width));
  assign dh_full = (dst_height == '0) ? 32'd1 :
                   ((32'(dst_height) > 32'(MAX_DST_HEIGHT)) ? 32'(MAX_DST_HEIGHT) :
                    32'(dst_height));
  assign sw = sw_full[SWW-1:0];
  assign sh = sh_full[SHW-1:0];
  assign dw = dw_full[DWW-1:0];
  assign dh = dh_full[DHW-1:0];

  // load position, restarted if a size shrank beneath it
  assign lcol_eff = (SWW'(load_column) >= sw) ? '0 : load_column;
  assign lrow_eff = (SHW'(load_row) >= sh) ? '0 : load_row;
  assign lcol_inc = SWW'(lcol_eff) + 1'b1;
  assign lrow_inc = SHW'(lrow_eff) + 1'b1;

  always_comb begin
    load_column_next = lcol_inc[LCW-1:0];
    load_row_next    = lrow_eff;
    if (lcol_inc >= sw) begin
      load_column_next = '0;
      load_row_next    = (lrow_inc >= sh) ? '0 : lrow_inc[LRW-1:0];
    end
  end

  assign wrow  = flip_rows ? (sh - 1'b1 - SHW'(lrow_eff)) : SHW'(lrow_eff);
  assign waddr = AW'(wrow) * AW'(MAX_SRC_WIDTH) + AW'(lcol_eff);

  // fetch position
  assign ocol_eff = (DWW'(out_column) >= dw) ? '0 : out_column;
  assign orow_eff = (DHW'(out_row) >= dh) ? '0 : out_row;
  assign ocol_inc = DWW'(ocol_eff) + 1'b1;
  assign orow_inc = DHW'(orow_eff) + 1'b1;
  assign last_now = (ocol_inc == dw) && (orow_inc == dh);

  always_comb begin
    out_column_next = ocol_inc[CW-1:0];
    out_row_next    = orow_eff;
    if (ocol_inc >= dw) begin
      out_column_next = '0;
      out_row_next    = (orow_inc >= dh) ? '0 : orow_inc[RW-1:0];
    end
  end

  assign raddr = AW'(qy) * AW'(MAX_SRC_WIDTH) + AW'(qx);
  assign bit_x = (rem_x >= dsx);
  assign bit_y = (rem_y >= dsy);
  assign accept = in.valid && in.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (accept && in.operation == OP_FETCH) state_next = F_DIV;
      F_DIV:  if (step == '0) state_next = F_PUSH;
      F_PUSH: if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in.ready       = 1'b0;
    push           = 1'b0;
    push_cmd.fetch = OP_FETCH;
    push_cmd.last  = last_hold;
    push_cmd.pixel = '0;
    push_addr      = raddr;
    case (state)
      F_IDLE: begin
        in.ready       = !q_full;
        push           = in.valid && !q_full && (in.operation == OP_LOAD);
        push_cmd.fetch = OP_LOAD;
        push_cmd.last  = 1'b0;
        push_cmd.pixel = pack_rgb565(in.red, in.green, in.blue);
        push_addr      = waddr;
      end
      F_PUSH: push = !q_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      load_column <= '0;
      load_row    <= '0;
      out_column  <= '0;
      out_row     <= '0;
      step        <= '0;
    end else begin
      state <= state_next;
      if (accept && in.operation == OP_LOAD) begin
        load_column <= load_column_next;
        load_row    <= load_row_next;
      end
      if (accept && in.operation == OP_FETCH) begin
        out_column <= out_column_next;
        out_row    <= out_row_next;
        step       <= STW'(QB - 1);
      end else if (state == F_DIV) begin
        step <= step - 1'b1;
      end
    end
  end

  // restoring division, one quotient bit per cycle for both axes
  always_ff @(posedge clk) begin
    if (accept && in.operation == OP_FETCH) begin
      rem_x     <= NW'(ocol_eff) * NW'(sw);
      rem_y     <= NW'(orow_eff) * NW'(sh);
      dsx       <= NW'(dw) << (QB - 1);
      dsy       <= NW'(dh) << (QB - 1);
      qx        <= '0;
      qy        <= '0;
      last_hold <= last_now;
    end else if (state == F_DIV) begin
      rem_x <= bit_x ? rem_x - dsx : rem_x;
      rem_y <= bit_y ? rem_y - dsy : rem_y;
      dsx   <= dsx >> 1;
      dsy   <= dsy >> 1;
      qx    <= QB'({qx, bit_x});
      qy    <= QB'({qy, bit_y});
    end
  end

  a_quotient_in_source: assert property (@(posedge clk) disable iff (rst)
    state == F_PUSH |-> (NW'(qx) < NW'(sw)) && (NW'(qy) < NW'(sh)))
    else $error("source coordinate outside source image");

  a_remainder_reduced: assert property (@(posedge clk) disable iff (rst)
    state == F_PUSH |-> (rem_x < NW'(dw)) && (rem_y < NW'(dh)))
    else $error("division left an unreduced remainder");

endmodule

### hw/rtl/nns_back.sv
// Back end: image store, registered read and output register.
// Depends on nns_pkg and nns_out_if.
module nns_back import nns_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  localparam int AW = (MAX_SRC_WIDTH * MAX_SRC_HEIGHT > 1) ?
                      $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  cmd_t          q_cmd,
  input  logic [AW-1:0] q_addr,
  output logic          pop,
  nns_out_if.source     out
);

  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;

  logic [PIXEL_W-1:0] store [DEPTH];
  logic [PIXEL_W-1:0] rdata;
  logic               r_valid;
  logic               r_last;
  logic               o_valid;
  logic [PIXEL_W-1:0] o_pixel;
  logic               o_last;
  logic               out_free;
  logic               r_move;
  logic               pop_fetch;

  assign out_free  = !o_valid || out.ready;
  assign r_move    = r_valid && out_free;
  // a fetch may only issue when its read slot will be empty next cycle
  assign pop       = q_valid && (!q_cmd.fetch || !r_valid || out_free);
  assign pop_fetch = pop && q_cmd.fetch;

  always_ff @(posedge clk) begin
    if (pop && !q_cmd.fetch) begin
      store[q_addr] <= q_cmd.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fetch) begin
      rdata  <= store[q_addr];
      r_last <= q_cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (r_move) begin
      o_pixel <= rdata;
      o_last  <= r_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (pop_fetch) begin
        r_valid <= 1'b1;
      end else if (r_move) begin
        r_valid <= 1'b0;
      end
      if (r_move) begin
        o_valid <= 1'b1;
      end else if (out.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  assign out.valid         = o_valid;
  assign out.pixel_rgb565  = o_pixel;
  assign out.last_of_frame = o_last;

  a_read_slot_kept: assert property (@(posedge clk) disable iff (rst)
    r_valid && !out_free |-> !pop_fetch)
    else $error("pending read overwritten");

endmodule

### hw/rtl/nearest_neighbor_scaler_rgb565.sv
// Top level of the nearest-neighbour RGB565 scaler.
// Depends on nns_pkg, nns_in_if, nns_out_if, nns_fifo, nns_front, nns_back.
//
// Usage:
//   Input words on "in": operation 0 loads one source pixel (blue, green,
//   red bytes, packed to RGB565 and stored, rows flipped when flip_rows is
//   set); operation 1 fetches the next destination pixel in raster order.
//   Each fetch yields one word on "out"; the final pixel of a frame carries
//   last_of_frame. Sizes and flip_rows are set through the write port
//   (cfg_write, cfg_index, cfg_data) while the block is idle.
//   Throughput: one load per cycle while the queue has room and no fetch
//   is in progress. A fetch holds the front end, taking no new word, while
//   the bit-per-cycle divider finds QB quotient bits for both source axes
//   in parallel (QB = width of the larger source counter, 8 at 256x256),
//   until its command is queued for the store read and output register.
//   Reset: counters to zero, sizes to 1, flip_rows to 1. The store is not
//   cleared; read only entries already loaded.
//   Receiver stall: the output register holds its word, a four-word queue
//   between front end and store absorbs commands, then in.ready drops.
module nearest_neighbor_scaler_rgb565 import nns_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int MAX_DST_WIDTH  = 1024,
  parameter int MAX_DST_HEIGHT = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  nns_in_if.sink                 in,
  nns_out_if.source              out,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = (MAX_SRC_WIDTH * MAX_SRC_HEIGHT > 1) ?
                      $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT) : 1;
  localparam int CMD_W = $bits(cmd_t);
  localparam int QW = AW + CMD_W;
  localparam int Q_DEPTH = 4;

  // front end to queue
  logic          f_push;
  cmd_t          f_cmd;
  logic [AW-1:0] f_addr;
  logic          q_full;

  // queue to back end
  logic [QW-1:0] q_data;
  logic          q_valid;
  logic          q_pop;
  cmd_t          q_cmd;
  logic [AW-1:0] q_addr;

  // accept words, count positions, divide out source coordinates
  nns_front #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .MAX_DST_WIDTH  (MAX_DST_WIDTH),
    .MAX_DST_HEIGHT (MAX_DST_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in        (in),
    .push      (f_push),
    .push_cmd  (f_cmd),
    .push_addr (f_addr),
    .q_full    (q_full)
  );

  // decouple the two halves so each stalls on its own
  nns_fifo #(
    .WIDTH (QW),
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data ({f_addr, f_cmd}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .valid     (q_valid)
  );

  assign q_addr = q_data[QW-1 -: AW];
  assign q_cmd  = cmd_t'(q_data[CMD_W-1:0]);

  // write or read the store, hold the result for the receiver
  nns_back #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_addr  (q_addr),
    .pop     (q_pop),
    .out     (out)
  );

endmodule

### bench/tb_nearest_neighbor_scaler_rgb565.sv
`timescale 1ns / 1ps
// Self-checking bench for the nearest-neighbour RGB565 scaler: drives load and
// fetch words, predicts every destination pixel in-bench and compares results.
// Depends on nns_pkg, nns_in_if, nns_out_if and nearest_neighbor_scaler_rgb565.
module tb_nearest_neighbor_scaler_rgb565;
  import nns_pkg::*;

  localparam int SRC_MAX_W     = 256;
  localparam int SRC_MAX_H     = 256;
  localparam int DST_MAX_W     = 1024;
  localparam int DST_MAX_H     = 1024;
  localparam int SETTLE_CYCLES = 40;       // comfortably above the fetch latency
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_ITEMS  = 180;
  localparam int TIMEOUT_NS    = 5_000_000;

  typedef struct packed {
    logic               op;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } in_word_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               last;
  } pixel_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  nns_in_if  in_ch ();
  nns_out_if out_ch ();

  nearest_neighbor_scaler_rgb565 i_dut (
    .clk       (clk),
    .rst       (rst),
    .in        (in_ch),
    .out       (out_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Words waiting for the driver, and destination pixels owed by the block.
  in_word_t pending_words[$];
  pixel_t   due_pixels[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int phase_no       = 0;

  // ---------------------------------------------------------------------------
  // Scaler prediction: register copy, image store and both raster counters.
  // ---------------------------------------------------------------------------
  logic [SRC_SIZE_W-1:0] src_w_reg     = SRC_SIZE_W'(1);
  logic [SRC_SIZE_W-1:0] src_h_reg     = SRC_SIZE_W'(1);
  logic                  flip_rows_reg = 1'b1;
  logic [DST_SIZE_W-1:0] dst_w_reg     = DST_SIZE_W'(1);
  logic [DST_SIZE_W-1:0] dst_h_reg     = DST_SIZE_W'(1);

  logic [PIXEL_W-1:0] pix_store [0:SRC_MAX_W*SRC_MAX_H-1];
  int unsigned ld_col  = 0;
  int unsigned ld_row  = 0;
  int unsigned out_col = 0;
  int unsigned out_row = 0;

  // A zero size behaves as one; anything above the maximum as the maximum.
  function automatic int unsigned eff_size(int unsigned raw, int unsigned max_v);
    if (raw == 0) return 1;
    return (raw > max_v) ? max_v : raw;
  endfunction

  task automatic scale_word(input in_word_t w);
    int unsigned sw;
    int unsigned sh;
    int unsigned dw;
    int unsigned dh;
    int unsigned row;
    int unsigned sx;
    int unsigned sy;
    pixel_t      want;
    sw = eff_size(src_w_reg, SRC_MAX_W);
    sh = eff_size(src_h_reg, SRC_MAX_H);
    dw = eff_size(dst_w_reg, DST_MAX_W);
    dh = eff_size(dst_h_reg, DST_MAX_H);
    if (w.op == OP_LOAD) begin
      // Restart a counter left beyond a shrunk size before using it.
      if (ld_col >= sw) ld_col = 0;
      if (ld_row >= sh) ld_row = 0;
      row = flip_rows_reg ? (sh - 1 - ld_row) : ld_row;
      pix_store[row * SRC_MAX_W + ld_col] = {w.red[7:3], w.green[7:2], w.blue[7:3]};
      ld_col++;
      if (ld_col >= sw) begin
        ld_col = 0;
        ld_row++;
        if (ld_row >= sh) ld_row = 0;
      end
    end else begin
      if (out_col >= dw) out_col = 0;
      if (out_row >= dh) out_row = 0;
      sx = out_col * sw / dw;
      sy = out_row * sh / dh;
      want.pixel = pix_store[sy * SRC_MAX_W + sx];
      want.last  = (out_col == dw - 1) && (out_row == dh - 1);
      due_pixels.push_back(want);
      out_col++;
      if (out_col >= dw) begin
        out_col = 0;
        out_row++;
        if (out_row >= dh) out_row = 0;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present the next pending word whenever the channel is free, and
  // feed each accepted word to the prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_words
    in_word_t nxt;
    in_word_t held;
    if (rst) begin
      in_ch.valid     <= 1'b0;
      in_ch.operation <= OP_LOAD;
      in_ch.blue      <= '0;
      in_ch.green     <= '0;
      in_ch.red       <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) scale_word(held);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt  = pending_words.pop_front();
          held = nxt;
          in_ch.valid     <= 1'b1;
          in_ch.operation <= nxt.op;
          in_ch.blue      <= nxt.blue;
          in_ch.green     <= nxt.green;
          in_ch.red       <= nxt.red;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted result word with the oldest owed pixel,
  // then choose ready for the next cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_pixels.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t: unexpected word pixel=%h last=%b", $realtime,
                     out_ch.pixel_rgb565, out_ch.last_of_frame);
          fail_count++;
        end else begin
          want = due_pixels.pop_front();
          if (out_ch.pixel_rgb565 !== want.pixel || out_ch.last_of_frame !== want.last) begin
            if (fail_count < MAX_REPORTS)
              $display("%0t: mismatch pixel exp=%h got=%h last exp=%b got=%b", $realtime,
                       want.pixel, out_ch.pixel_rgb565, want.last, out_ch.last_of_frame);
            fail_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_word(input logic op, input logic [7:0] b, input logic [7:0] g,
                           input logic [7:0] r);
    in_word_t w;
    w.op    = op;
    w.blue  = b;
    w.green = g;
    w.red   = r;
    pending_words.push_back(w);
  endtask

  // Hold until every word is taken and every pixel returned, then let any
  // trailing loads clear the pipeline.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_ch.valid || due_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_SRC_WIDTH:  src_w_reg     = val[SRC_SIZE_W-1:0];
      CFG_SRC_HEIGHT: src_h_reg     = val[SRC_SIZE_W-1:0];
      CFG_FLIP_ROWS:  flip_rows_reg = val[0];
      CFG_DST_WIDTH:  dst_w_reg     = val[DST_SIZE_W-1:0];
      CFG_DST_HEIGHT: dst_h_reg     = val[DST_SIZE_W-1:0];
      default: ;
    endcase
  endtask

  // Reprogram every register while idle, pick this phase's idling, and return
  // the number of loads that cover the whole source frame.
  task automatic configure(input logic [10:0] sw, input logic [10:0] sh, input logic bu,
                           input logic [10:0] dw, input logic [10:0] dh,
                           output int unsigned frame_loads);
    idle_mode_t mode;
    wait_idle();
    write_reg(CFG_SRC_WIDTH, sw);
    write_reg(CFG_SRC_HEIGHT, sh);
    write_reg(CFG_FLIP_ROWS, CFG_DATA_W'(bu));
    write_reg(CFG_DST_WIDTH, dw);
    write_reg(CFG_DST_HEIGHT, dh);
    // An index past the register list must leave everything untouched.
    if ($urandom_range(2) == 0)
      write_reg(CFG_DST_HEIGHT + CFG_INDEX_W'($urandom_range(1, 3)), CFG_DATA_W'($urandom));
    mode = idle_mode_t'(phase_no % 4);
    phase_no++;
    case (mode)
      IDLE_NONE:     begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
      IDLE_SENDER:   begin send_idle_pct <= 78; recv_stall_pct <= 0;  end
      IDLE_RECEIVER: begin send_idle_pct <= 0;  recv_stall_pct <= 78; end
      default:       begin send_idle_pct <= 32; recv_stall_pct <= 32; end
    endcase
    @(negedge clk);
    frame_loads = eff_size(src_w_reg, SRC_MAX_W) * eff_size(src_h_reg, SRC_MAX_H);
  endtask

  // A full frame of loads first, so every fetch reads a written entry; then a
  // random mix in which stray colour bytes ride on fetches too.
  task automatic queue_phase(input int unsigned n_fill, input int unsigned n_mix,
                             input int fetch_pct);
    for (int unsigned i = 0; i < n_fill; i++)
      push_word(OP_LOAD, 8'($urandom), 8'($urandom), 8'($urandom));
    for (int unsigned i = 0; i < n_mix; i++)
      push_word(($urandom_range(99) < fetch_pct) ? OP_FETCH : OP_LOAD,
                8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  function automatic logic [10:0] pick_src_size();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 10) return 11'd0;
    if (p < 20) return 11'($urandom_range(9, 40));
    if (p < 28) return 11'($urandom_range(257, 2047));
    return 11'($urandom_range(1, 8));
  endfunction

  function automatic logic [10:0] pick_dst_size();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 10) return 11'd0;
    if (p < 20) return 11'($urandom_range(13, 60));
    if (p < 28) return 11'($urandom_range(1025, 2047));
    return 11'($urandom_range(1, 12));
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned random_items;
    int unsigned fill;
    int unsigned mix;
    logic [10:0] sw_raw;
    logic [10:0] sh_raw;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: 1x1 frames from reset, colour extremes and the bits that the
    // packing drops; fetches carry other colour bytes, to be ignored.
    @(negedge clk);
    push_word(OP_LOAD,  8'hFF, 8'hFF, 8'hFF);
    push_word(OP_FETCH, 8'h00, 8'h00, 8'h00);
    push_word(OP_LOAD,  8'h00, 8'h00, 8'h00);
    push_word(OP_FETCH, 8'hFF, 8'hFF, 8'hFF);
    push_word(OP_LOAD,  8'h07, 8'h03, 8'h07);
    push_word(OP_FETCH, 8'hA5, 8'h5A, 8'hC3);
    push_word(OP_LOAD,  8'hF8, 8'hFC, 8'hF8);
    push_word(OP_FETCH, 8'h00, 8'hFF, 8'h00);

    // Directed: 2x2 top-down source scaled up to 3x3, one complete frame.
    configure(11'd2, 11'd2, 1'b0, 11'd3, 11'd3, fill);
    push_word(OP_LOAD, 8'hFF, 8'h00, 8'h00);
    push_word(OP_LOAD, 8'h00, 8'hFF, 8'h00);
    push_word(OP_LOAD, 8'h00, 8'h00, 8'hFF);
    push_word(OP_LOAD, 8'h80, 8'h80, 8'h80);
    for (int i = 0; i < 9; i++) push_word(OP_FETCH, 8'($urandom), 8'($urandom), 8'($urandom));

    // Tallest source, top row first, into the tallest destination.
    configure(11'd1, 11'd256, 1'b0, 11'd5, 11'd1024, fill);
    queue_phase(fill, 60, 70);
    // All sizes zero: each behaves as one.
    configure(11'd0, 11'd0, 1'b0, 11'd0, 11'd0, fill);
    queue_phase(fill, 20, 70);
    // Sizes above their maxima saturate, giving the widest source and the
    // widest destination; the source height masks down to one.
    configure(11'h7FF, 11'h201, 1'b1, 11'h7FF, 11'd1500, fill);
    queue_phase(fill, 60, 70);

    // Random phases: mostly small frames, fill then a load/fetch mix.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      sw_raw = pick_src_size();
      sh_raw = pick_src_size();
      // Keep the fill short: a frame of more than 128 pixels drops to a single row.
      if (eff_size(sw_raw[8:0], SRC_MAX_W) * eff_size(sh_raw[8:0], SRC_MAX_H) > 128)
        sh_raw = 11'd1;
      mix = $urandom_range(30, 90);
      configure(sw_raw, sh_raw, 1'($urandom), pick_dst_size(), pick_dst_size(), fill);
      queue_phase(fill, mix, 70);
      random_items += fill + mix;
    end

    wait_idle();
    if (fail_count == 0 && due_pixels.size() == 0) begin
      $display("tb_nearest_neighbor_scaler_rgb565 passed");
    end else begin
      $display("tb_nearest_neighbor_scaler_rgb565 failed");
    end
    $finish;
  end

  // Stop a run that hangs on a lost word.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb_nearest_neighbor_scaler_rgb565 failed");
    $finish;
  end

endmodule
